[design/archive_stream_parser_assert.svh]
// assertion macros used by the checker file
`ifndef ARCHIVE_STREAM_PARSER_ASSERT_SVH
`define ARCHIVE_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define ASP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/asp_pkg.sv]
`default_nettype none

package asp_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  // header byte positions
  localparam logic [2:0] HDR_MAGIC_LAST = 3'd3;
  localparam logic [2:0] HDR_VERSION    = 3'd4;
  localparam logic [2:0] HDR_COUNT_LO   = 3'd5;
  localparam logic [2:0] LEN32_LAST     = 3'd3;

  typedef enum logic [2:0] {
    PH_HEADER      = 3'd0,
    PH_NAME_LEN    = 3'd1,
    PH_NAME        = 3'd2,
    PH_CONTENT_LEN = 3'd3,
    PH_CONTENT     = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUNNING     = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CLS_HEADER      = 3'd0,
    CLS_NAME_LEN    = 3'd1,
    CLS_NAME        = 3'd2,
    CLS_CONTENT_LEN = 3'd3,
    CLS_CONTENT     = 3'd4,
    CLS_IGNORED     = 3'd5
  } class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic   valid;
    item_t  item;
  } head_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  format_version;
  } cfg_t;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    logic [QUEUE_PTR_W-1:0] r;
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/asp_stream_if.sv]
`default_nettype none

interface asp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface asp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [2:0]  byte_class;
  logic [15:0] file_number;
  logic        record_done;
  logic [2:0]  parse_status;

  modport source (
    output valid, output byte_value, output byte_class, output file_number,
    output record_done, output parse_status, input ready
  );
  modport sink (
    input valid, input byte_value, input byte_class, input file_number,
    input record_done, input parse_status, output ready
  );
endinterface

`default_nettype wire

[design/asp_queue.sv]
`default_nettype none

module asp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  asp_in_if.sink              request,
  output asp_pkg::head_t      head,
  input  wire logic           pop
);

  asp_pkg::item_t entries [asp_pkg::QUEUE_DEPTH];
  logic [asp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [asp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [asp_pkg::QUEUE_CNT_W-1:0] count;
  logic [asp_pkg::QUEUE_CNT_W-1:0] count_next;
  logic push;

  assign request.ready = (count != asp_pkg::QUEUE_CNT_W'(asp_pkg::QUEUE_DEPTH));
  assign push = request.valid && request.ready;

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (!push && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= asp_pkg::ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= asp_pkg::ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{data_byte: request.data_byte, last_byte: request.last_byte};
    end
  end

endmodule

`default_nettype wire

[design/asp_parser.sv]
`default_nettype none

module asp_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire asp_pkg::cfg_t  cfg,
  input  wire asp_pkg::head_t head,
  output logic                pop,
  asp_out_if.source           result
);

  asp_pkg::phase_t  phase, phase_next;
  asp_pkg::status_t status, status_next;
  logic [2:0]  field_count, field_count_next;
  logic [31:0] field_acc, field_acc_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [15:0] files_left, files_left_next;
  logic [15:0] cur_file, cur_file_next;

  asp_pkg::class_t cls;
  logic [15:0] fnum;
  logic        done;
  logic        close_rec;
  logic [7:0]  b;
  logic        last;
  logic [31:0] acc_ins;
  logic [15:0] len16;
  logic [15:0] files_dec;

  logic        out_valid;
  logic [7:0]  out_byte;
  asp_pkg::class_t  out_class;
  logic [15:0] out_file;
  logic        out_done;
  asp_pkg::status_t out_status;

  assign b    = head.item.data_byte;
  assign last = head.item.last_byte;
  assign pop  = head.valid && (!out_valid || result.ready);

  // byte inserted at the lane given by the field byte count
  assign acc_ins   = field_acc | ({24'd0, b} << {field_count[1:0], 3'b000});
  assign len16     = {b, field_acc[7:0]};
  assign files_dec = files_left - 1'b1;

  always_comb begin
    phase_next       = phase;
    status_next      = status;
    field_count_next = field_count;
    field_acc_next   = field_acc;
    bytes_left_next  = bytes_left;
    files_left_next  = files_left;
    cur_file_next    = cur_file;
    cls       = asp_pkg::CLS_IGNORED;
    fnum      = '0;
    close_rec = 1'b0;

    if (status == asp_pkg::ST_RUNNING) begin
      unique case (phase)
        asp_pkg::PH_HEADER: begin
          cls = asp_pkg::CLS_HEADER;
          priority if (field_count <= asp_pkg::HDR_MAGIC_LAST) begin
            field_acc_next   = acc_ins;
            field_count_next = field_count + 1'b1;
            if (field_count == asp_pkg::HDR_MAGIC_LAST) begin
              if (acc_ins != cfg.magic_word) begin
                status_next = asp_pkg::ST_BAD_MAGIC;
              end
              field_acc_next = '0;
            end
          end else if (field_count == asp_pkg::HDR_VERSION) begin
            if (b != cfg.format_version) begin
              status_next = asp_pkg::ST_BAD_VERSION;
            end
            field_count_next = field_count + 1'b1;
          end else if (field_count == asp_pkg::HDR_COUNT_LO) begin
            field_acc_next   = {24'd0, b};
            field_count_next = field_count + 1'b1;
          end else begin
            field_acc_next   = '0;
            field_count_next = '0;
            if (len16 == '0) begin
              status_next = asp_pkg::ST_COMPLETE;
            end else begin
              files_left_next = len16;
              phase_next      = asp_pkg::PH_NAME_LEN;
            end
          end
        end
        asp_pkg::PH_NAME_LEN: begin
          cls  = asp_pkg::CLS_NAME_LEN;
          fnum = cur_file;
          if (field_count == '0) begin
            field_acc_next   = {24'd0, b};
            field_count_next = 3'd1;
          end else begin
            field_acc_next   = '0;
            field_count_next = '0;
            bytes_left_next  = {16'd0, len16};
            phase_next = (len16 == '0) ? asp_pkg::PH_CONTENT_LEN : asp_pkg::PH_NAME;
          end
        end
        asp_pkg::PH_NAME: begin
          cls  = asp_pkg::CLS_NAME;
          fnum = cur_file;
          bytes_left_next = bytes_left - 1'b1;
          if (bytes_left == 32'd1) begin
            phase_next = asp_pkg::PH_CONTENT_LEN;
          end
        end
        asp_pkg::PH_CONTENT_LEN: begin
          cls  = asp_pkg::CLS_CONTENT_LEN;
          fnum = cur_file;
          field_acc_next = acc_ins;
          if (field_count >= asp_pkg::LEN32_LAST) begin
            field_acc_next   = '0;
            field_count_next = '0;
            if (acc_ins == '0) begin
              close_rec = 1'b1;
            end else begin
              bytes_left_next = acc_ins;
              phase_next      = asp_pkg::PH_CONTENT;
            end
          end else begin
            field_count_next = field_count + 1'b1;
          end
        end
        asp_pkg::PH_CONTENT: begin
          cls  = asp_pkg::CLS_CONTENT;
          fnum = cur_file;
          bytes_left_next = bytes_left - 1'b1;
          if (bytes_left == 32'd1) begin
            close_rec = 1'b1;
          end
        end
        default: begin
          cls  = asp_pkg::CLS_CONTENT;
          fnum = cur_file;
        end
      endcase
    end

    done = close_rec;
    if (close_rec) begin
      files_left_next  = files_dec;
      cur_file_next    = cur_file + 1'b1;
      field_count_next = '0;
      field_acc_next   = '0;
      if (files_dec == '0) begin
        status_next = asp_pkg::ST_COMPLETE;
      end else begin
        phase_next = asp_pkg::PH_NAME_LEN;
      end
    end

    if (last && status_next == asp_pkg::ST_RUNNING) begin
      status_next = asp_pkg::ST_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= asp_pkg::PH_HEADER;
      status      <= asp_pkg::ST_RUNNING;
      field_count <= '0;
      field_acc   <= '0;
      bytes_left  <= '0;
      files_left  <= '0;
      cur_file    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (last) begin
          // end of buffer: next byte starts a new archive
          phase       <= asp_pkg::PH_HEADER;
          status      <= asp_pkg::ST_RUNNING;
          field_count <= '0;
          field_acc   <= '0;
          bytes_left  <= '0;
          files_left  <= '0;
          cur_file    <= '0;
        end else begin
          phase       <= phase_next;
          status      <= status_next;
          field_count <= field_count_next;
          field_acc   <= field_acc_next;
          bytes_left  <= bytes_left_next;
          files_left  <= files_left_next;
          cur_file    <= cur_file_next;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte   <= b;
      out_class  <= cls;
      out_file   <= fnum;
      out_done   <= done;
      out_status <= status_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.byte_value   = out_byte;
  assign result.byte_class   = out_class;
  assign result.file_number  = out_file;
  assign result.record_done  = out_done;
  assign result.parse_status = out_status;

endmodule

`default_nettype wire

[design/archive_stream_parser.sv]
// Archive stream parser: takes one archive byte per request and returns one tagged
// result per byte (class, file index, record-done flag, sticky status), one byte per
// cycle sustained while the result side is ready. A request passes a two-entry queue
// and the parser's output register before its result is offered; the parser state
// (field count, length counters, status) is updated as each byte leaves the queue.
// Set magic_word (address 0) and format_version (address 4) while the stream is idle.
`default_nettype none

module archive_stream_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  asp_in_if.sink                               request,
  asp_out_if.source                            result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [asp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [asp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [asp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  asp_pkg::cfg_t  cfg;
  asp_pkg::head_t head;
  logic pop;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word     <= '0;
      cfg.format_version <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        asp_pkg::REG_MAGIC:   cfg.magic_word     <= pwdata;
        asp_pkg::REG_VERSION: cfg.format_version <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      asp_pkg::REG_MAGIC:   prdata = cfg.magic_word;
      asp_pkg::REG_VERSION: prdata = {24'd0, cfg.format_version};
      default:              prdata = '0;
    endcase
  end

  asp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .head    (head),
    .pop     (pop)
  );

  asp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

[design/asp_checker.sv]
`default_nettype none
`include "archive_stream_parser_assert.svh"

module asp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  byte_class,
  input wire logic [15:0] file_number,
  input wire logic        record_done,
  input wire logic [2:0]  parse_status
);

  // ignored bytes carry no record tagging
  `ASP_ASSERT_NOW(a_ignored_untagged, res_valid && byte_class == asp_pkg::CLS_IGNORED, file_number == '0 && !record_done, "ignored byte tagged with a record")
  // ignored bytes only appear once the status has settled
  `ASP_ASSERT_NOW(a_ignored_settled, res_valid && byte_class == asp_pkg::CLS_IGNORED, parse_status != asp_pkg::ST_RUNNING, "ignored byte while still running")
  // a record closes only on a content or content-length byte
  `ASP_ASSERT_NOW(a_done_class, res_valid && record_done, byte_class == asp_pkg::CLS_CONTENT || byte_class == asp_pkg::CLS_CONTENT_LEN, "record closed on wrong byte class")
  // a stalled result stays offered
  `ASP_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid, "result dropped while stalled")

endmodule

bind archive_stream_parser asp_checker u_asp_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .byte_class   (result.byte_class),
  .file_number  (result.file_number),
  .record_done  (result.record_done),
  .parse_status (result.parse_status)
);

`default_nettype wire

[sim/archive_stream_parser_tb.sv]
`default_nettype none

module archive_stream_parser_tb;

  typedef struct {
    logic [7:0]        value;
    asp_pkg::class_t   cls;
    logic [15:0]       fnum;
    logic              done;
    asp_pkg::status_t  status;
  } tag_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } arc_byte_t;

  typedef struct {
    logic [7:0]        data;
    logic              last;
    bit                known;
    asp_pkg::class_t   cls;
    logic [15:0]       fnum;
    logic              done;
    asp_pkg::status_t  status;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [asp_pkg::APB_ADDR_W-1:0] paddr;
  logic [asp_pkg::APB_DATA_W-1:0] pwdata;
  wire  [asp_pkg::APB_DATA_W-1:0] prdata;
  wire                            pready;

  asp_in_if  req_if ();
  asp_out_if res_if ();

  archive_stream_parser uut (
    .clk(clk), .rst(rst), .request(req_if), .result(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // parser model state
  asp_pkg::phase_t  ph;
  logic [2:0]       fcnt;
  logic [31:0]      acc;
  logic [31:0]      remain;
  logic [15:0]      files_left;
  logic [15:0]      cur_file;
  asp_pkg::status_t sticky;
  logic [31:0]      cfg_magic;
  logic [7:0]       cfg_version;

  tag_t      pending_tags[$];
  arc_byte_t archive_q[$];
  int        error_count = 0;
  int        results_seen = 0;
  bit        steady_flow = 1'b0;
  bit        offer_known = 1'b0;
  tag_t      offer_tag;

  // stream 1: zero file count closed by the final byte
  // stream 2: bad magic, then an ignored final byte
  // stream 3: bad version on the final byte
  // stream 4: final byte on the first header byte
  // stream 5: one record with empty name and empty content
  step_row_t directed_rows [0:30] = '{
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b1, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_COMPLETE},
    '{8'hFF, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h80, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_BAD_MAGIC},
    '{8'h7F, 1'b1, 1'b1, asp_pkg::CLS_IGNORED, 16'd0, 1'b0, asp_pkg::ST_BAD_MAGIC},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h01, 1'b1, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_BAD_VERSION},
    '{8'hA5, 1'b1, 1'b1, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_TRUNCATED},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h01, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b0, 1'b0, asp_pkg::CLS_HEADER, 16'd0, 1'b0, asp_pkg::ST_RUNNING},
    '{8'h00, 1'b1, 1'b1, asp_pkg::CLS_CONTENT_LEN, 16'd0, 1'b1, asp_pkg::ST_COMPLETE}
  };

  function automatic void clear_parse_state();
    ph = asp_pkg::PH_HEADER;
    fcnt = '0;
    acc = '0;
    remain = '0;
    files_left = '0;
    cur_file = '0;
    sticky = asp_pkg::ST_RUNNING;
  endfunction

  function automatic logic finish_record();
    files_left = files_left - 1'b1;
    cur_file = cur_file + 1'b1;
    fcnt = '0;
    acc = '0;
    if (files_left == 16'd0) sticky = asp_pkg::ST_COMPLETE;
    else ph = asp_pkg::PH_NAME_LEN;
    return 1'b1;
  endfunction

  function automatic tag_t parse_byte(input logic [7:0] b, input logic last);
    tag_t        t;
    logic [15:0] len16;
    logic [31:0] len32;
    t.value = b;
    t.cls = asp_pkg::CLS_IGNORED;
    t.fnum = '0;
    t.done = 1'b0;
    if (sticky == asp_pkg::ST_RUNNING) begin
      case (ph)
        asp_pkg::PH_HEADER: begin
          t.cls = asp_pkg::CLS_HEADER;
          if (fcnt < 3'd4) begin
            acc = acc | (32'(b) << (8 * fcnt[1:0]));
            if (fcnt == asp_pkg::HDR_MAGIC_LAST) begin
              if (acc != cfg_magic) sticky = asp_pkg::ST_BAD_MAGIC;
              acc = '0;
            end
            fcnt = fcnt + 1'b1;
          end else if (fcnt == asp_pkg::HDR_VERSION) begin
            if (b != cfg_version) sticky = asp_pkg::ST_BAD_VERSION;
            fcnt = fcnt + 1'b1;
          end else if (fcnt == asp_pkg::HDR_COUNT_LO) begin
            acc = 32'(b);
            fcnt = fcnt + 1'b1;
          end else begin
            len16 = {b, acc[7:0]};
            acc = '0;
            fcnt = '0;
            if (len16 == 16'd0) begin
              sticky = asp_pkg::ST_COMPLETE;
            end else begin
              files_left = len16;
              ph = asp_pkg::PH_NAME_LEN;
            end
          end
        end
        asp_pkg::PH_NAME_LEN: begin
          t.cls = asp_pkg::CLS_NAME_LEN;
          t.fnum = cur_file;
          if (fcnt == 3'd0) begin
            acc = 32'(b);
            fcnt = 3'd1;
          end else begin
            len16 = {b, acc[7:0]};
            acc = '0;
            fcnt = '0;
            remain = 32'(len16);
            ph = (len16 == 16'd0) ? asp_pkg::PH_CONTENT_LEN : asp_pkg::PH_NAME;
          end
        end
        asp_pkg::PH_NAME: begin
          t.cls = asp_pkg::CLS_NAME;
          t.fnum = cur_file;
          remain = remain - 1'b1;
          if (remain == 32'd0) ph = asp_pkg::PH_CONTENT_LEN;
        end
        asp_pkg::PH_CONTENT_LEN: begin
          t.cls = asp_pkg::CLS_CONTENT_LEN;
          t.fnum = cur_file;
          acc = acc | (32'(b) << (8 * fcnt[1:0]));
          if (fcnt >= asp_pkg::LEN32_LAST) begin
            len32 = acc;
            acc = '0;
            fcnt = '0;
            if (len32 == 32'd0) begin
              t.done = finish_record();
            end else begin
              remain = len32;
              ph = asp_pkg::PH_CONTENT;
            end
          end else begin
            fcnt = fcnt + 1'b1;
          end
        end
        default: begin
          t.cls = asp_pkg::CLS_CONTENT;
          t.fnum = cur_file;
          remain = remain - 1'b1;
          if (remain == 32'd0) t.done = finish_record();
        end
      endcase
    end
    if (last && sticky == asp_pkg::ST_RUNNING) sticky = asp_pkg::ST_TRUNCATED;
    t.status = sticky;
    if (last) clear_parse_state();
    return t;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // requests in, results out, both sampled before this edge's updates land
  always @(posedge clk) begin
    tag_t want;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        want = parse_byte(req_if.data_byte, req_if.last_byte);
        if (offer_known) want = offer_tag;
        pending_tags.insert(pending_tags.size(), want);
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (pending_tags.size() == 0) begin
          $error("result with nothing pending: byte_value %0d", res_if.byte_value);
          error_count++;
        end else begin
          want = pending_tags.pop_front();
          check_field("byte_value", 32'(want.value), 32'(res_if.byte_value));
          check_field("byte_class", 32'(want.cls), 32'(res_if.byte_class));
          check_field("file_number", 32'(want.fnum), 32'(res_if.file_number));
          check_field("record_done", 32'(want.done), 32'(res_if.record_done));
          check_field("parse_status", 32'(want.status), 32'(res_if.parse_status));
        end
      end
    end
  end

  // result side: short random stalls plus one long hold-off
  initial begin
    int  stall_left;
    bit  held_off;
    stall_left = 0;
    held_off = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        stall_left = 59;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(4) == 0) begin
        stall_left = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_item(input logic [7:0] d, input logic l, input bit known,
                           input tag_t typed);
    if (!steady_flow && $urandom_range(5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data_byte <= d;
    req_if.last_byte <= l;
    offer_known = known;
    offer_tag = typed;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending_tags.size() != 0);
  endtask

  task automatic write_reg(input logic reg_index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_index == asp_pkg::REG_MAGIC) cfg_magic = value;
    else cfg_version = value[7:0];
  endtask

  function automatic void put(input logic [7:0] d);
    arc_byte_t ab;
    ab.data = d;
    ab.last = 1'b0;
    archive_q.insert(archive_q.size(), ab);
  endfunction

  // mostly well-formed archives with random content, some cut short,
  // some with a damaged header, some with garbage after a good header
  function automatic void build_archive();
    int          kind;
    int          nfiles;
    int          nlen;
    int          tail;
    logic [31:0] clen;
    logic [39:0] hdr;
    logic [15:0] count;
    archive_q.delete();
    kind = $urandom_range(99);
    hdr = {cfg_version, cfg_magic};
    if (kind >= 80 && kind < 90) hdr[$urandom_range(0, 39)] ^= 1'b1;
    for (int i = 0; i < 5; i++) put(hdr[8*i +: 8]);
    if (kind < 80) begin
      nfiles = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
      count = 16'(nfiles);
      put(count[7:0]);
      put(count[15:8]);
      for (int f = 0; f < nfiles; f++) begin
        nlen = $urandom_range(0, 3);
        put(8'(nlen));
        put(8'h00);
        for (int i = 0; i < nlen; i++) put(8'($urandom));
        clen = 32'($urandom_range(0, 4));
        for (int i = 0; i < 4; i++) put(clen[8*i +: 8]);
        for (int i = 0; i < clen; i++) put(8'($urandom));
      end
      tail = $urandom_range(0, 2);
      for (int i = 0; i < tail; i++) put(8'($urandom));
      if (kind >= 70) begin
        tail = $urandom_range(1, archive_q.size());
        while (archive_q.size() > tail) void'(archive_q.pop_back());
      end
    end else begin
      count = 16'($urandom);
      put(count[7:0]);
      put(count[15:8]);
      tail = $urandom_range(1, 12);
      for (int i = 0; i < tail; i++) put(8'($urandom));
    end
    archive_q[archive_q.size() - 1].last = 1'b1;
  endfunction

  initial begin
    tag_t        typed;
    int          phase_sent;
    bit          paused;
    logic [31:0] magic_set;
    logic [7:0]  version_set;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data_byte = '0;
    req_if.last_byte = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    paused = 1'b0;
    cfg_magic = '0;
    cfg_version = '0;
    clear_parse_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers still at their reset values here
    foreach (directed_rows[i]) begin
      typed = '{directed_rows[i].data, directed_rows[i].cls, directed_rows[i].fnum,
                directed_rows[i].done, directed_rows[i].status};
      send_item(directed_rows[i].data, directed_rows[i].last, directed_rows[i].known,
                typed);
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin magic_set = 32'hFFFF_FFFF; version_set = 8'hFF; end
        2: begin magic_set = 32'h0000_0000; version_set = 8'h00; end
        default: begin magic_set = $urandom; version_set = 8'($urandom); end
      endcase
      write_reg(asp_pkg::REG_MAGIC, magic_set);
      write_reg(asp_pkg::REG_VERSION, 32'(version_set));
      steady_flow = (phase == 3);
      phase_sent = 0;
      while (phase_sent < 180) begin
        build_archive();
        foreach (archive_q[i]) send_item(archive_q[i].data, archive_q[i].last, 1'b0, typed);
        phase_sent += archive_q.size();
        // sender goes quiet until the pipeline is empty
        if (phase == 1 && !paused && phase_sent >= 90) begin
          paused = 1'b1;
          drain_results();
        end
      end
      drain_results();
    end

    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
